/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the dual motor PWM register block.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define AST_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition in one cycle leads to another in the next.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AST_ALWAYS(label, clk, rst_n, cond, msg)
`define AST_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/dmpwm_pkg.sv */
// Package of the dual motor PWM register block: widths, constants, codes,
// status types and saturation helpers. Depends on nothing.
package dmpwm_pkg;

	localparam int DUTY_W      = 14;
	localparam int FREQ_W      = 20;
	localparam int REG_W       = 16;
	localparam int CLK_W       = 28;
	localparam int FREQ_IN_W   = 24;
	localparam int DUTY_IN_W   = 16;
	localparam int MUL_B_W     = 17;
	localparam int MUL_W       = FREQ_W + MUL_B_W;
	localparam int DIV_W       = 30;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	localparam logic [DUTY_W-1:0]    DUTY_FULL_SCALE = 14'd10000;
	localparam logic [FREQ_W-1:0]    FREQ_MAX_HZ     = 20'd1000000;
	localparam logic [MUL_B_W-1:0]   TARGET_COUNTS   = 17'd1000;
	localparam logic [CLK_W-1:0]     CLOCK_RESET_HZ  = 28'd72000000;
	localparam logic [REG_W-1:0]     RELOAD_RESET    = 16'd4234;
	localparam logic [REG_W-1:0]     REG16_MAX       = 16'hFFFF;

	// Request codes.
	localparam logic [1:0] REQ_SPEED  = 2'd0;
	localparam logic [1:0] REQ_DIR    = 2'd1;
	localparam logic [1:0] REQ_FREQ   = 2'd2;
	localparam logic [1:0] REQ_ENABLE = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Clip a quotient to 16 bits.
	function automatic logic [REG_W-1:0] sat16(input logic [DIV_W-1:0] v);
		if (v > DIV_W'(REG16_MAX))
			return REG16_MAX;
		return v[REG_W-1:0];
	endfunction

	// Quotient minus one, floored at zero and clipped to 16 bits.
	function automatic logic [REG_W-1:0] sat16_dec(input logic [DIV_W-1:0] v);
		logic [DIV_W-1:0] m;
		m = v - DIV_W'(1);
		if (v == '0)
			return '0;
		if (m > DIV_W'(REG16_MAX))
			return REG16_MAX;
		return m[REG_W-1:0];
	endfunction

endpackage

/* rtl/dmpwm_if.sv */
// Request and result channel interfaces of the dual motor PWM register block.
// Depends on dmpwm_pkg for field widths.
interface dmpwm_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        req_type;
	logic                              motor_select;
	logic [dmpwm_pkg::DUTY_IN_W-1:0]   duty_request;
	logic                              forward;
	logic [dmpwm_pkg::FREQ_IN_W-1:0]   frequency_hz;
	logic                              enable_request;

	modport source (output valid, req_type, motor_select, duty_request, forward,
		frequency_hz, enable_request, input ready);
	modport sink (input valid, req_type, motor_select, duty_request, forward,
		frequency_hz, enable_request, output ready);
endinterface

interface dmpwm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [dmpwm_pkg::REG_W-1:0]   prescaler;
	logic [dmpwm_pkg::REG_W-1:0]   reload;
	logic [dmpwm_pkg::REG_W-1:0]   compare_right;
	logic [dmpwm_pkg::REG_W-1:0]   compare_left;
	logic                          dir_pin_right;
	logic                          dir_pin_left;
	logic                          enable_pin;

	modport source (output valid, prescaler, reload, compare_right, compare_left,
		dir_pin_right, dir_pin_left, enable_pin, input ready);
	modport sink (input valid, prescaler, reload, compare_right, compare_left,
		dir_pin_right, dir_pin_left, enable_pin, output ready);
endinterface

/* rtl/dual_motor_pwm_register_block.sv */
// Dual motor PWM register block: one request at a time, result after it.
// Direction and enable requests go straight to the finish state; speed scales one
// compare value and frequency scales prescaler, reload and both compare values in
// turn, each through the shared multiplier and 30-step divider. Next request is taken once the
// sequencer is back in idle. Asynchronous active-low reset restores the
// power-up registers (reload 4234, both motors forward, 72 MHz timer clock).
`include "assert_macros.svh"

module dual_motor_pwm_register_block (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dmpwm_pkg::CLK_W-1:0]   cfg_wdata,
	dmpwm_req_if.sink                     req,
	dmpwm_rsp_if.source                   rsp
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_WB     = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	// Which scaled value the shared unit is working on.
	localparam logic [2:0] PH_SPEED = 3'd0;
	localparam logic [2:0] PH_PSC   = 3'd1;
	localparam logic [2:0] PH_ARR   = 3'd2;
	localparam logic [2:0] PH_CMPR  = 3'd3;
	localparam logic [2:0] PH_CMPL  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] phase_q;

	// Architectural registers.
	logic [dmpwm_pkg::CLK_W-1:0]  clk_hz_q;
	logic [dmpwm_pkg::REG_W-1:0]  prescaler_q;
	logic [dmpwm_pkg::REG_W-1:0]  reload_q;
	logic [dmpwm_pkg::DUTY_W-1:0] duty_right_q;
	logic [dmpwm_pkg::DUTY_W-1:0] duty_left_q;
	logic [dmpwm_pkg::REG_W-1:0]  cmp_right_q;
	logic [dmpwm_pkg::REG_W-1:0]  cmp_left_q;
	logic                         fwd_right_q;
	logic                         fwd_left_q;
	logic                         enable_q;

	// Per-request working registers.
	logic                         sel_q;
	logic [dmpwm_pkg::FREQ_W-1:0] freq_q;

	// Result holding register.
	logic                         out_valid_q;
	logic [dmpwm_pkg::REG_W-1:0]  out_psc_q;
	logic [dmpwm_pkg::REG_W-1:0]  out_arr_q;
	logic [dmpwm_pkg::REG_W-1:0]  out_cmpr_q;
	logic [dmpwm_pkg::REG_W-1:0]  out_cmpl_q;
	logic                         out_dirr_q;
	logic                         out_dirl_q;
	logic                         out_en_q;

	logic                         accept;
	logic                         out_free;
	logic [dmpwm_pkg::DUTY_W-1:0] duty_clamped;
	logic [dmpwm_pkg::FREQ_W-1:0] freq_clamped;

	// Shared multiplier and divider hookup.
	logic [dmpwm_pkg::FREQ_W-1:0]  mul_a;
	logic [dmpwm_pkg::MUL_B_W-1:0] mul_b;
	logic [dmpwm_pkg::MUL_W-1:0]   product;
	logic [dmpwm_pkg::DIV_W-1:0]   div_num;
	logic [dmpwm_pkg::MUL_W-1:0]   div_den;
	logic [dmpwm_pkg::DIV_W-1:0]   div_quot;
	logic                          div_start;
	dmpwm_pkg::div_stat_t          div_stat;
	logic [dmpwm_pkg::MUL_B_W-1:0] reload_p1;
	logic                          clk_phase;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Clamp duty to full scale and frequency to 1 Hz .. 1 MHz.
	always_comb begin
		if (req.duty_request > dmpwm_pkg::DUTY_IN_W'(dmpwm_pkg::DUTY_FULL_SCALE))
			duty_clamped = dmpwm_pkg::DUTY_FULL_SCALE;
		else
			duty_clamped = req.duty_request[dmpwm_pkg::DUTY_W-1:0];

		if (req.frequency_hz == '0)
			freq_clamped = dmpwm_pkg::FREQ_W'(1);
		else if (req.frequency_hz > dmpwm_pkg::FREQ_IN_W'(dmpwm_pkg::FREQ_MAX_HZ))
			freq_clamped = dmpwm_pkg::FREQ_MAX_HZ;
		else
			freq_clamped = req.frequency_hz[dmpwm_pkg::FREQ_W-1:0];
	end

	// Operand select: prescaler and reload divide the timer clock by a
	// frequency product; compare values divide reload+1 times duty by full scale.
	assign reload_p1 = dmpwm_pkg::MUL_B_W'(reload_q) + 1'b1;
	assign clk_phase = (phase_q == PH_PSC) || (phase_q == PH_ARR);

	always_comb begin
		case (phase_q)
			PH_PSC: begin
				mul_a = freq_q;
				mul_b = dmpwm_pkg::TARGET_COUNTS;
			end
			PH_ARR: begin
				mul_a = freq_q;
				mul_b = dmpwm_pkg::MUL_B_W'(prescaler_q) + 1'b1;
			end
			PH_CMPR: begin
				mul_a = dmpwm_pkg::FREQ_W'(duty_right_q);
				mul_b = reload_p1;
			end
			PH_CMPL: begin
				mul_a = dmpwm_pkg::FREQ_W'(duty_left_q);
				mul_b = reload_p1;
			end
			default: begin
				mul_a = dmpwm_pkg::FREQ_W'(sel_q ? duty_left_q : duty_right_q);
				mul_b = reload_p1;
			end
		endcase
	end

	assign product   = dmpwm_pkg::MUL_W'(mul_a) * dmpwm_pkg::MUL_W'(mul_b);
	// Duty product stays below 2^30, so the upper bits are zero there.
	assign div_num   = clk_phase ? dmpwm_pkg::DIV_W'(clk_hz_q) : product[dmpwm_pkg::DIV_W-1:0];
	assign div_den   = clk_phase ? product : dmpwm_pkg::MUL_W'(dmpwm_pkg::DUTY_FULL_SCALE);
	assign div_start = (state_q == ST_MUL);

	dmpwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Timer clock configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= dmpwm_pkg::CLOCK_RESET_HZ;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	// Sequencer and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_SPEED;
			prescaler_q  <= '0;
			reload_q     <= dmpwm_pkg::RELOAD_RESET;
			duty_right_q <= '0;
			duty_left_q  <= '0;
			cmp_right_q  <= '0;
			cmp_left_q   <= '0;
			fwd_right_q  <= 1'b1;
			fwd_left_q   <= 1'b1;
			enable_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							dmpwm_pkg::REQ_SPEED: begin
								// Store the clamped duty now, scale it next.
								if (req.motor_select)
									duty_left_q <= duty_clamped;
								else
									duty_right_q <= duty_clamped;
								phase_q <= PH_SPEED;
								state_q <= ST_MUL;
							end
							dmpwm_pkg::REQ_DIR: begin
								if (req.motor_select)
									fwd_left_q <= req.forward;
								else
									fwd_right_q <= req.forward;
								state_q <= ST_FINISH;
							end
							dmpwm_pkg::REQ_FREQ: begin
								phase_q <= PH_PSC;
								state_q <= ST_MUL;
							end
							default: begin
								enable_q <= req.enable_request;
								state_q  <= ST_FINISH;
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done)
						state_q <= ST_WB;
				end
				ST_WB: begin
					// Commit the quotient and advance the frequency chain, or finish after the last value.
					case (phase_q)
						PH_PSC: begin
							prescaler_q <= dmpwm_pkg::sat16_dec(div_quot);
							phase_q     <= PH_ARR;
							state_q     <= ST_MUL;
						end
						PH_ARR: begin
							reload_q <= dmpwm_pkg::sat16_dec(div_quot);
							phase_q  <= PH_CMPR;
							state_q  <= ST_MUL;
						end
						PH_CMPR: begin
							cmp_right_q <= dmpwm_pkg::sat16(div_quot);
							phase_q     <= PH_CMPL;
							state_q     <= ST_MUL;
						end
						PH_CMPL: begin
							cmp_left_q <= dmpwm_pkg::sat16(div_quot);
							state_q    <= ST_FINISH;
						end
						default: begin
							if (sel_q)
								cmp_left_q <= dmpwm_pkg::sat16(div_quot);
							else
								cmp_right_q <= dmpwm_pkg::sat16(div_quot);
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_FINISH: begin
					// Hold until the result register is free.
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request operands kept for the duration of the sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q  <= req.motor_select;
			freq_q <= freq_clamped;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Snapshot of the register image.
	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_psc_q  <= prescaler_q;
			out_arr_q  <= reload_q;
			out_cmpr_q <= cmp_right_q;
			out_cmpl_q <= cmp_left_q;
			out_dirr_q <= fwd_right_q;
			out_dirl_q <= !fwd_left_q;
			out_en_q   <= enable_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.prescaler     = out_psc_q;
	assign rsp.reload        = out_arr_q;
	assign rsp.compare_right = out_cmpr_q;
	assign rsp.compare_left  = out_cmpl_q;
	assign rsp.dir_pin_right = out_dirr_q;
	assign rsp.dir_pin_left  = out_dirl_q;
	assign rsp.enable_pin    = out_en_q;

	`AST_NEXT(a_speed_starts_mul, clk, arst_n, accept && (req.req_type == dmpwm_pkg::REQ_SPEED), (state_q == ST_MUL) && (phase_q == PH_SPEED), "speed request did not start scaling")
	`AST_ALWAYS(a_div_only_in_div, clk, arst_n, !div_stat.busy || (state_q == ST_DIV), "divider busy outside the divide state")
	`AST_ALWAYS(a_duty_in_range, clk, arst_n, (duty_right_q <= dmpwm_pkg::DUTY_FULL_SCALE) && (duty_left_q <= dmpwm_pkg::DUTY_FULL_SCALE), "stored duty above full scale")
	`AST_NEXT(a_finish_waits, clk, arst_n, (state_q == ST_FINISH) && out_valid_q && !rsp.ready, state_q == ST_FINISH, "result overwritten while still pending")

endmodule

/* rtl/dmpwm_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dmpwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmpwm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dmpwm_pkg::DIV_W-1:0]   num,
	input  logic [dmpwm_pkg::MUL_W-1:0]   den,
	output logic [dmpwm_pkg::DIV_W-1:0]   quot,
	output dmpwm_pkg::div_stat_t          stat
);

	logic [dmpwm_pkg::DIV_W-1:0]     num_q;
	logic [dmpwm_pkg::DIV_W-1:0]     rem_q;
	logic [dmpwm_pkg::MUL_W-1:0]     den_q;
	logic [dmpwm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [dmpwm_pkg::DIV_W-1:0]     trial;
	logic                            fits;

	// Partial remainder stays below 2^(DIV_W-1), so the shift loses nothing.
	assign trial = {rem_q[dmpwm_pkg::DIV_W-2:0], num_q[dmpwm_pkg::DIV_W-1]};
	assign fits  = dmpwm_pkg::MUL_W'(trial) >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dmpwm_pkg::DIV_CNT_W'(dmpwm_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial - den_q[dmpwm_pkg::DIV_W-1:0] : trial;
			num_q <= {num_q[dmpwm_pkg::DIV_W-2:0], fits};
		end
	end

	assign quot      = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`AST_ALWAYS(a_div_no_restart, clk, arst_n, !(start && busy_q), "divider restarted while busy")
	`AST_ALWAYS(a_div_rem_below, clk, arst_n, !busy_q || (dmpwm_pkg::MUL_W'(rem_q) < den_q), "partial remainder not below divisor")
	`AST_NEXT(a_div_done_idle, clk, arst_n, done_q, !busy_q && !done_q, "done not a single pulse after the run")

endmodule

/* bench/dual_motor_pwm_register_block_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the dual motor PWM register block: directed table, then random
// requests under several timer clocks. Depends on dmpwm_pkg, dmpwm_if and the block itself.
module dual_motor_pwm_register_block_test;
	import dmpwm_pkg::*;

	// One request as it goes over the request channel.
	typedef struct packed {
		logic [1:0]           kind;
		logic                 motor;
		logic [DUTY_IN_W-1:0] duty;
		logic                 fwd;
		logic [FREQ_IN_W-1:0] freq;
		logic                 en;
	} pwm_request_t;

	// Register image reported after every request.
	typedef struct packed {
		logic [REG_W-1:0] prescaler;
		logic [REG_W-1:0] reload;
		logic [REG_W-1:0] compare_right;
		logic [REG_W-1:0] compare_left;
		logic             dir_pin_right;
		logic             dir_pin_left;
		logic             enable_pin;
	} pwm_image_t;

	// Image typed in by hand for a directed row, or left to the shadow registers.
	typedef struct packed {
		logic       given;
		pwm_image_t image;
	} typed_image_t;

	typedef struct packed {
		pwm_request_t stim;
		typed_image_t want;
	} directed_row_t;

	localparam int DIRECTED_ROWS  = 23;
	localparam int PHASES         = 10;
	localparam int PHASE_REQUESTS = 143;
	// Longest request (frequency) plus margin, used for the drain at the end.
	localparam int DRAIN_CYCLES   = 140;
	localparam int DRAIN_LIMIT    = 5000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CLK_W-1:0] cfg_wdata;

	dmpwm_req_if req_ch();
	dmpwm_rsp_if rsp_ch();

	dual_motor_pwm_register_block DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the block's registers, advanced at every accepted request.
	logic [CLK_W-1:0]  shadow_clock_hz = CLOCK_RESET_HZ;
	logic [REG_W-1:0]  shadow_prescaler = '0;
	logic [REG_W-1:0]  shadow_reload = RELOAD_RESET;
	logic [DUTY_W-1:0] shadow_duty_right = '0;
	logic [DUTY_W-1:0] shadow_duty_left = '0;
	logic [REG_W-1:0]  shadow_compare_right = '0;
	logic [REG_W-1:0]  shadow_compare_left = '0;
	logic              shadow_fwd_right = 1'b1;
	logic              shadow_fwd_left = 1'b1;
	logic              shadow_enable = 1'b0;

	pwm_image_t   pending_images[$];
	typed_image_t typed_images[$];
	int           mismatch_count = 0;

	// Stimulus knobs for the request driver and the result sink.
	bit               quiet = 1'b0;
	int               sender_idle_pct = 0;
	logic [CLK_W-1:0] timer_clock_setting = CLOCK_RESET_HZ;

	// Directed table, written against the power-up state with the 72 MHz clock.
	// Rows with a given image are read straight off the arithmetic; the rest go
	// through the shadow registers.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// Enable low with all other fields zero: the power-up image.
		'{'{REQ_ENABLE, 1'b0, 16'd0, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd0, 16'd4234, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0}}},
		// Largest duty clamps to full scale: compare is reload+1.
		'{'{REQ_SPEED, 1'b0, 16'hFFFF, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd0, 1'b1, 1'b0, 1'b0}}},
		'{'{REQ_SPEED, 1'b1, 16'd10000, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd4235, 1'b1, 1'b0, 1'b0}}},
		// Just above full scale.
		'{'{REQ_SPEED, 1'b1, 16'd10001, 1'b1, 24'hFFFFFF, 1'b1},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd4235, 1'b1, 1'b0, 1'b0}}},
		'{'{REQ_SPEED, 1'b1, 16'd0, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd0, 1'b1, 1'b0, 1'b0}}},
		'{'{REQ_SPEED, 1'b1, 16'd9999, 1'b0, 24'd0, 1'b0}, '{1'b0, '0}},
		// Right backward drops its pin; left backward raises the inverted pin.
		'{'{REQ_DIR, 1'b0, 16'd0, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd4234, 1'b0, 1'b0, 1'b0}}},
		'{'{REQ_DIR, 1'b1, 16'd0, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd4234, 1'b0, 1'b1, 1'b0}}},
		'{'{REQ_DIR, 1'b0, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1}, '{1'b0, '0}},
		'{'{REQ_DIR, 1'b1, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1}, '{1'b0, '0}},
		'{'{REQ_ENABLE, 1'b0, 16'd0, 1'b0, 24'd0, 1'b1},
			'{1'b1, '{16'd0, 16'd4234, 16'd4235, 16'd4234, 1'b1, 1'b0, 1'b1}}},
		'{'{REQ_ENABLE, 1'b1, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b0}, '{1'b0, '0}},
		// Zero frequency becomes 1 Hz: prescaler saturates, reload 72e6/65536-1.
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd0, 1'b0},
			'{1'b1, '{16'd65535, 16'd1097, 16'd1098, 16'd1097, 1'b1, 1'b0, 1'b0}}},
		// Top of the field clamps to 1 MHz: prescaler floors at zero.
		'{'{REQ_FREQ, 1'b1, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1},
			'{1'b1, '{16'd0, 16'd71, 16'd72, 16'd71, 1'b1, 1'b0, 1'b0}}},
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd1000000, 1'b0}, '{1'b0, '0}},
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd1000001, 1'b0}, '{1'b0, '0}},
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd1, 1'b0}, '{1'b0, '0}},
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd1000, 1'b0}, '{1'b0, '0}},
		// Both sides of the point where clock/(f*1000) reaches one.
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd72000, 1'b0}, '{1'b0, '0}},
		'{'{REQ_FREQ, 1'b0, 16'd0, 1'b0, 24'd72001, 1'b0}, '{1'b0, '0}},
		'{'{REQ_SPEED, 1'b0, 16'd1, 1'b0, 24'd0, 1'b0}, '{1'b0, '0}},
		'{'{REQ_SPEED, 1'b0, 16'd10000, 1'b0, 24'd0, 1'b0}, '{1'b0, '0}},
		'{'{REQ_FREQ, 1'b1, 16'd0, 1'b0, 24'd20000, 1'b0}, '{1'b0, '0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic [REG_W-1:0] clip16(input longint unsigned v);
		return (v > 64'(REG16_MAX)) ? REG16_MAX : REG_W'(v);
	endfunction

	// Compare value for a duty at the current reload: (reload+1)*duty/full scale.
	function automatic logic [REG_W-1:0] compare_for(input logic [DUTY_W-1:0] duty);
		longint unsigned product;
		product = (64'(shadow_reload) + 64'd1) * 64'(duty);
		return clip16(product / 64'(DUTY_FULL_SCALE));
	endfunction

	// Advance the shadow registers by one request and return the reported image.
	function automatic pwm_image_t apply_command(input pwm_request_t r);
		longint unsigned hz;
		longint unsigned ticks;
		logic [DUTY_W-1:0] duty;
		duty = (r.duty > 16'(DUTY_FULL_SCALE)) ? DUTY_FULL_SCALE : r.duty[DUTY_W-1:0];
		case (r.kind)
			REQ_SPEED: begin
				if (r.motor) begin
					shadow_duty_left = duty;
					shadow_compare_left = compare_for(duty);
				end else begin
					shadow_duty_right = duty;
					shadow_compare_right = compare_for(duty);
				end
			end
			REQ_DIR: begin
				if (r.motor)
					shadow_fwd_left = r.fwd;
				else
					shadow_fwd_right = r.fwd;
			end
			REQ_FREQ: begin
				hz = 64'(r.freq);
				if (hz < 64'd1)
					hz = 64'd1;
				if (hz > 64'(FREQ_MAX_HZ))
					hz = 64'(FREQ_MAX_HZ);
				// Floor both quotients minus one at zero rather than wrapping.
				ticks = 64'(shadow_clock_hz) / (hz * 64'(TARGET_COUNTS));
				shadow_prescaler = clip16((ticks == 0) ? 64'd0 : ticks - 64'd1);
				ticks = 64'(shadow_clock_hz) / (hz * (64'(shadow_prescaler) + 64'd1));
				shadow_reload = clip16((ticks == 0) ? 64'd0 : ticks - 64'd1);
				shadow_compare_right = compare_for(shadow_duty_right);
				shadow_compare_left = compare_for(shadow_duty_left);
			end
			default: shadow_enable = r.en;
		endcase
		return '{shadow_prescaler, shadow_reload, shadow_compare_right, shadow_compare_left,
			shadow_fwd_right, ~shadow_fwd_left, shadow_enable};
	endfunction

	// Monitor both channels at every edge. Register writes land first, then an
	// accepted request queues its image, then a delivered result is checked.
	always @(posedge clk) begin
		pwm_request_t seen;
		pwm_image_t predicted;
		pwm_image_t got;
		pwm_image_t want;
		typed_image_t typed;
		if (arst_n) begin
			if (cfg_we)
				shadow_clock_hz = cfg_wdata;
			if (req_ch.valid && req_ch.ready) begin
				seen = '{req_ch.req_type, req_ch.motor_select, req_ch.duty_request,
					req_ch.forward, req_ch.frequency_hz, req_ch.enable_request};
				predicted = apply_command(seen);
				typed = (typed_images.size() != 0) ? typed_images.pop_front() : '0;
				pending_images.push_back(typed.given ? typed.image : predicted);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.prescaler, rsp_ch.reload, rsp_ch.compare_right,
					rsp_ch.compare_left, rsp_ch.dir_pin_right, rsp_ch.dir_pin_left,
					rsp_ch.enable_pin};
				if (pending_images.size() == 0) begin
					report_mismatch("result with no request outstanding", 1, 0);
				end else begin
					want = pending_images.pop_front();
					if (got.prescaler !== want.prescaler)
						report_mismatch("prescaler", got.prescaler, want.prescaler);
					if (got.reload !== want.reload)
						report_mismatch("reload", got.reload, want.reload);
					if (got.compare_right !== want.compare_right)
						report_mismatch("compare_right", got.compare_right, want.compare_right);
					if (got.compare_left !== want.compare_left)
						report_mismatch("compare_left", got.compare_left, want.compare_left);
					if (got.dir_pin_right !== want.dir_pin_right)
						report_mismatch("dir_pin_right", got.dir_pin_right, want.dir_pin_right);
					if (got.dir_pin_left !== want.dir_pin_left)
						report_mismatch("dir_pin_left", got.dir_pin_left, want.dir_pin_left);
					if (got.enable_pin !== want.enable_pin)
						report_mismatch("enable_pin", got.enable_pin, want.enable_pin);
				end
			end
		end
	end

	// Result sink: change the stall rate at random between none, 8 and 30 percent,
	// and drop ready in bursts of random length. Hold ready high when quiet.
	initial begin
		int stall_pct;
		int cycle;
		stall_pct = 0;
		cycle = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 256 == 0)
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 30;
				endcase
			if (!quiet && arst_n && $urandom_range(0, 99) < stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Drive one request and return at the edge that accepts it. Valid is left
	// high so a request that follows at once keeps it up without a dip.
	task automatic send_request(input pwm_request_t r, input typed_image_t want);
		if (!quiet && $urandom_range(0, 99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		typed_images.push_back(want);
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= r.kind;
		req_ch.motor_select   <= r.motor;
		req_ch.duty_request   <= r.duty;
		req_ch.forward        <= r.fwd;
		req_ch.frequency_hz   <= r.freq;
		req_ch.enable_request <= r.en;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Write the timer clock with the block idle: drop valid, drain every
	// outstanding result, then let it settle back before the write.
	task automatic set_timer_clock(input logic [CLK_W-1:0] hz);
		req_ch.valid <= 1'b0;
		while (pending_images.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we <= 1'b0;
		timer_clock_setting = hz;
	endtask

	function automatic logic [FREQ_IN_W-1:0] pick_frequency();
		longint unsigned corner;
		case ($urandom_range(0, 5))
			0: return FREQ_IN_W'($urandom_range(0, 20));
			1: return FREQ_IN_W'($urandom_range(1, 1000));
			2: return FREQ_IN_W'($urandom_range(1000, 1000000));
			3: return FREQ_IN_W'($urandom_range(999990, 1000010));
			4: return FREQ_IN_W'($urandom);
			default: begin
				// Land near clock/1000, where the prescaler falls to zero.
				corner = 64'(timer_clock_setting) / 64'd1000;
				corner = corner + 64'($urandom_range(0, 4));
				corner = (corner > 64'd2) ? corner - 64'd2 : corner;
				return FREQ_IN_W'(corner);
			end
		endcase
	endfunction

	function automatic pwm_request_t random_request();
		pwm_request_t r;
		r.kind  = 2'($urandom_range(0, 3));
		r.motor = 1'($urandom);
		r.fwd   = 1'($urandom);
		r.en    = 1'($urandom);
		r.freq  = pick_frequency();
		case ($urandom_range(0, 3))
			0: r.duty = DUTY_IN_W'($urandom_range(0, 10000));
			1: r.duty = DUTY_IN_W'($urandom_range(9995, 10005));
			2: r.duty = DUTY_IN_W'($urandom);
			default: r.duty = DUTY_IN_W'($urandom_range(0, 3));
		endcase
		return r;
	endfunction

	initial begin
		logic [CLK_W-1:0] hz;
		int drain;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = REQ_SPEED;
		req_ch.motor_select   = 1'b0;
		req_ch.duty_request   = '0;
		req_ch.forward        = 1'b0;
		req_ch.frequency_hz   = '0;
		req_ch.enable_request = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run at the power-up clock with occasional sender gaps.
		sender_idle_pct = 20;
		foreach (directed_rows[i])
			send_request(directed_rows[i].stim, directed_rows[i].want);

		// Random phases, each under its own timer clock: the ends of the random range, the field
		// extremes, a clock too slow for the top frequency, the power-up value, then random.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: hz = 28'd1000000;
				1: hz = 28'd200000000;
				2: hz = '0;
				3: hz = '1;
				4: hz = 28'd999999;
				5: hz = CLOCK_RESET_HZ;
				8: hz = CLK_W'($urandom);
				default: hz = CLK_W'($urandom_range(1000000, 200000000));
			endcase
			set_timer_clock(hz);
			case ($urandom_range(0, 2))
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 15;
				default: sender_idle_pct = 40;
			endcase
			// Run the last phase flat out on both sides.
			quiet = (phase == PHASES - 1);
			for (int n = 0; n < PHASE_REQUESTS; n++)
				send_request(random_request(), '0);
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding results with a bound, then let the block settle.
		drain = 0;
		while (pending_images.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_images.size() != 0)
			report_mismatch("results never delivered", 0, pending_images.size());

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
